### rtl/core/qbn_pkg.sv
package qbn_pkg;

    localparam int MAX_SEEDS  = 4096;
    localparam int IDX_W      = 12;
    localparam int PIX_W      = 24;
    localparam int NRM_W      = 24;
    localparam int DIM_W      = 7;
    localparam int CELL_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_BITS  = 20;
    localparam int DIFF_W     = PIX_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DET_W      = PROD_W + 1;
    localparam int MID_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN   = 7'd2;
    localparam logic [DIM_W-1:0] DIM_MAX   = 7'd64;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd2;

    localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } grid_cfg_t;

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        entry_index;
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic                    entry_valid;
    } item_t;

    typedef struct packed {
        item_t             it;
        logic [CELL_W-1:0] qx0;
        logic [CELL_W-1:0] qy0;
        logic              oob;
    } mid_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mid_status_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pos_x;
        logic signed [PIX_W-1:0] pos_y;
        logic signed [NRM_W-1:0] nrm_x;
        logic signed [NRM_W-1:0] nrm_y;
        logic                    valid;
    } seed_t;

    typedef struct packed {
        logic                    fb;
        logic signed [NRM_W-1:0] fb_x;
        logic signed [NRM_W-1:0] fb_y;
        logic [3:0][NRM_W-1:0]   cn_x;
        logic [3:0][NRM_W-1:0]   cn_y;
    } blend_side_t;

    typedef struct packed {
        logic [DET_W-1:0] n_x;
        logic [DET_W-1:0] n_y;
        logic [DET_W-1:0] d;
        logic             zero_x;
        logic             zero_y;
        blend_side_t      side;
    } div_in_t;

    typedef struct packed {
        logic                    status;
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
    } result_t;

endpackage

### rtl/core/qbn_front.sv
module qbn_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qbn_pkg::grid_cfg_t     cfg,
    input  logic                   push,
    input  qbn_pkg::item_t         in_item,
    input  qbn_pkg::mid_status_t   mid_st,
    output logic                   stall,
    output logic                   mid_push,
    output qbn_pkg::mid_item_t     mid_item
);
    import qbn_pkg::*;

    localparam int WH_W = 2 * DIM_W;

    typedef struct packed {
        item_t            it;
        logic             oob;
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] quo;
    } fstage_t;

    fstage_t          st_reg  [IDX_W+1];
    fstage_t          st_next [IDX_W+1];
    logic [IDX_W:0]   v_reg;
    logic             en;
    logic [WH_W-1:0]  wh;

    assign en    = !mid_st.full;
    assign stall = !en;
    assign wh    = WH_W'(cfg.w) * WH_W'(cfg.h);

    // restoring divide of the index by the grid width, one quotient bit per stage
    always_comb
    begin
        logic [DIM_W:0] t;
        st_next[0].it  = in_item;
        st_next[0].oob = WH_W'(in_item.entry_index) >= wh;
        st_next[0].rem = '0;
        st_next[0].quo = '0;
        for (int k = 1; k <= IDX_W; k++)
        begin
            st_next[k] = st_reg[k-1];
            t = {st_reg[k-1].rem, st_reg[k-1].it.entry_index[IDX_W-k]};
            if (t >= {1'b0, cfg.w})
            begin
                st_next[k].rem = DIM_W'(t - {1'b0, cfg.w});
                st_next[k].quo = {st_reg[k-1].quo[IDX_W-2:0], 1'b1};
            end
            else
            begin
                st_next[k].rem = t[DIM_W-1:0];
                st_next[k].quo = {st_reg[k-1].quo[IDX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[IDX_W-1:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= IDX_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign mid_push     = en && v_reg[IDX_W];
    assign mid_item.it  = st_reg[IDX_W].it;
    assign mid_item.oob = st_reg[IDX_W].oob;
    assign mid_item.qx0 = st_reg[IDX_W].rem[CELL_W-1:0];
    assign mid_item.qy0 = st_reg[IDX_W].quo[CELL_W-1:0];

endmodule

### rtl/core/qbn_mid_fifo.sv
module qbn_mid_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  qbn_pkg::mid_item_t   in_item,
    input  logic                 pop,
    output qbn_pkg::mid_item_t   out_item,
    output qbn_pkg::mid_status_t st
);
    import qbn_pkg::*;

    localparam int PTR_W = $clog2(MID_DEPTH);

    mid_item_t        mem_reg [MID_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign st.full  = cnt_reg == (PTR_W + 1)'(MID_DEPTH);
    assign st.empty = cnt_reg == '0;
    assign out_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/qbn_frac_div.sv
module qbn_frac_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_v,
    input  qbn_pkg::div_in_t        din,
    output logic                    out_v,
    output logic [qbn_pkg::FRAC_BITS:0] frac_x,
    output logic [qbn_pkg::FRAC_BITS:0] frac_y,
    output qbn_pkg::blend_side_t    side
);
    import qbn_pkg::*;

    localparam int NST = FRAC_BITS + 2;

    typedef struct packed {
        logic [DET_W-1:0]     rx;
        logic [DET_W-1:0]     ry;
        logic [FRAC_BITS-1:0] qx;
        logic [FRAC_BITS-1:0] qy;
        logic [DET_W-1:0]     d;
        logic                 zero_x;
        logic                 zero_y;
        logic                 one_x;
        logic                 one_y;
        blend_side_t          side;
    } dstage_t;

    dstage_t        st_reg  [NST];
    dstage_t        st_next [NST];
    logic [NST-1:0] v_reg;

    // stage 0 latches, stage 1 catches quotients of one or more,
    // the rest take one quotient bit each in both lanes
    always_comb
    begin
        logic [DET_W:0] tx;
        logic [DET_W:0] ty;
        st_next[0].rx     = din.n_x;
        st_next[0].ry     = din.n_y;
        st_next[0].qx     = '0;
        st_next[0].qy     = '0;
        st_next[0].d      = din.d;
        st_next[0].zero_x = din.zero_x;
        st_next[0].zero_y = din.zero_y;
        st_next[0].one_x  = 1'b0;
        st_next[0].one_y  = 1'b0;
        st_next[0].side   = din.side;
        st_next[1]        = st_reg[0];
        st_next[1].one_x  = st_reg[0].rx >= st_reg[0].d;
        st_next[1].one_y  = st_reg[0].ry >= st_reg[0].d;
        for (int k = 2; k < NST; k++)
        begin
            st_next[k] = st_reg[k-1];
            tx = {st_reg[k-1].rx, 1'b0};
            ty = {st_reg[k-1].ry, 1'b0};
            if (tx >= {1'b0, st_reg[k-1].d})
            begin
                st_next[k].rx = DET_W'(tx - {1'b0, st_reg[k-1].d});
                st_next[k].qx = {st_reg[k-1].qx[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                st_next[k].rx = tx[DET_W-1:0];
                st_next[k].qx = {st_reg[k-1].qx[FRAC_BITS-2:0], 1'b0};
            end
            if (ty >= {1'b0, st_reg[k-1].d})
            begin
                st_next[k].ry = DET_W'(ty - {1'b0, st_reg[k-1].d});
                st_next[k].qy = {st_reg[k-1].qy[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                st_next[k].ry = ty[DET_W-1:0];
                st_next[k].qy = {st_reg[k-1].qy[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_v  = v_reg[NST-1];
    assign side   = st_reg[NST-1].side;
    assign frac_x = st_reg[NST-1].zero_x ? '0 :
                    st_reg[NST-1].one_x  ? FRAC_ONE : {1'b0, st_reg[NST-1].qx};
    assign frac_y = st_reg[NST-1].zero_y ? '0 :
                    st_reg[NST-1].one_y  ? FRAC_ONE : {1'b0, st_reg[NST-1].qy};

endmodule

### rtl/core/qbn_back.sv
module qbn_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qbn_pkg::grid_cfg_t   cfg,
    input  qbn_pkg::mid_status_t mid_st,
    input  qbn_pkg::mid_item_t   head,
    output logic                 mid_pop,
    output logic                 clearing,
    input  logic                 res_pop,
    output logic                 res_empty,
    output qbn_pkg::result_t     res
);
    import qbn_pkg::*;

    localparam int PW    = CELL_W + DIM_W;
    localparam int MW    = FRAC_BITS + 2 + NRM_W;
    localparam int TOP_W = MW + 1;
    localparam int LO_W  = 22;
    localparam int HI_W  = TOP_W - LO_W;
    localparam int HP_W  = FRAC_BITS + 2 + HI_W;
    localparam int LP_W  = FRAC_BITS + 1 + LO_W;
    localparam int VW    = 72;
    localparam int RSH   = 2 * FRAC_BITS;

    // seed stores: three copies, read at the nearest seed and at four corners
    seed_t mem0 [MAX_SEEDS];
    seed_t mem1 [MAX_SEEDS];
    seed_t mem2 [MAX_SEEDS];

    logic             clr_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             en;

    // result queue
    result_t    oq_reg [2];
    logic       oq_wr_reg;
    logic       oq_rd_reg;
    logic [1:0] oq_cnt_reg;
    logic       oq_push;
    result_t    oq_in;

    assign en        = oq_cnt_reg != 2'd2;
    assign clearing  = clr_reg;
    assign mid_pop   = en && !mid_st.empty && !clr_reg;
    assign res_empty = oq_cnt_reg == 2'd0;
    assign res       = oq_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    function automatic seed_t seed_of(item_t it);
        seed_t s;
        s.pos_x = it.pixel_x;
        s.pos_y = it.pixel_y;
        s.nrm_x = it.normal_x;
        s.nrm_y = it.normal_y;
        s.valid = it.entry_valid;
        return s;
    endfunction

    // ---------------- stage 1: nearest seed read
    logic      s1_v_reg;
    mid_item_t s1_reg;
    seed_t     m0_reg;

    logic             we0;
    logic [IDX_W-1:0] wa0;
    seed_t            wd0;

    assign we0 = clr_reg || (mid_pop && head.it.action == ACT_LOAD);
    assign wa0 = clr_reg ? clr_cnt_reg : head.it.entry_index;
    assign wd0 = clr_reg ? '0 : seed_of(head.it);

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[wa0] <= wd0;
        end
        if (mid_pop)
        begin
            m0_reg <= mem0[head.it.entry_index];
            s1_reg <= head;
        end
    end

    // quad selection
    logic signed [DIM_W:0] qx_raw;
    logic signed [DIM_W:0] qy_raw;
    logic [DIM_W-1:0]      wm2;
    logic [DIM_W-1:0]      hm2;
    logic [CELL_W-1:0]     qx;
    logic [CELL_W-1:0]     qy;
    logic [PW-1:0]         c0_full;
    logic [IDX_W-1:0]      ca [4];

    always_comb
    begin
        wm2    = cfg.w - DIM_MIN;
        hm2    = cfg.h - DIM_MIN;
        qx_raw = $signed({2'b00, s1_reg.qx0})
               - $signed({{DIM_W{1'b0}}, s1_reg.it.pixel_x < m0_reg.pos_x});
        qy_raw = $signed({2'b00, s1_reg.qy0})
               - $signed({{DIM_W{1'b0}}, s1_reg.it.pixel_y < m0_reg.pos_y});
        if (qx_raw[DIM_W])
        begin
            qx = '0;
        end
        else if (qx_raw > $signed({1'b0, wm2}))
        begin
            qx = wm2[CELL_W-1:0];
        end
        else
        begin
            qx = qx_raw[CELL_W-1:0];
        end
        if (qy_raw[DIM_W])
        begin
            qy = '0;
        end
        else if (qy_raw > $signed({1'b0, hm2}))
        begin
            qy = hm2[CELL_W-1:0];
        end
        else
        begin
            qy = qy_raw[CELL_W-1:0];
        end
        c0_full = PW'(qy) * PW'(cfg.w) + PW'(qx);
        ca[0]   = c0_full[IDX_W-1:0];
        ca[1]   = ca[0] + 1'b1;
        ca[2]   = ca[0] + IDX_W'(cfg.w);
        ca[3]   = ca[2] + 1'b1;
    end

    // ---------------- stage 2: corner reads
    logic             s2_v_reg;
    logic             s2_oob_reg;
    logic signed [PIX_W-1:0] s2_px_reg;
    logic signed [PIX_W-1:0] s2_py_reg;
    logic signed [NRM_W-1:0] s2_fbx_reg;
    logic signed [NRM_W-1:0] s2_fby_reg;
    seed_t            cr_reg [4];

    logic             we12;
    logic [IDX_W-1:0] wa12;
    seed_t            wd12;
    logic             s1_adv;

    assign s1_adv = en && s1_v_reg;
    assign we12   = clr_reg || (s1_adv && s1_reg.it.action == ACT_LOAD);
    assign wa12   = clr_reg ? clr_cnt_reg : s1_reg.it.entry_index;
    assign wd12   = clr_reg ? '0 : seed_of(s1_reg.it);

    always_ff @(posedge clk)
    begin
        if (we12)
        begin
            mem1[wa12] <= wd12;
            mem2[wa12] <= wd12;
        end
        if (s1_adv)
        begin
            cr_reg[0]  <= mem1[ca[0]];
            cr_reg[1]  <= mem1[ca[1]];
            cr_reg[2]  <= mem2[ca[2]];
            cr_reg[3]  <= mem2[ca[3]];
            s2_oob_reg <= s1_reg.oob;
            s2_px_reg  <= s1_reg.it.pixel_x;
            s2_py_reg  <= s1_reg.it.pixel_y;
            s2_fbx_reg <= s1_reg.oob ? '0 : m0_reg.nrm_x;
            s2_fby_reg <= s1_reg.oob ? '0 : m0_reg.nrm_y;
        end
    end

    // ---------------- stage 3: edge vectors
    logic                     s3_v_reg;
    logic                     s3_ok_reg;
    logic signed [DIFF_W-1:0] exx_reg, exy_reg, eyx_reg, eyy_reg, ox_reg, oy_reg;
    blend_side_t              s3_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ok_reg <= !s2_oob_reg && cr_reg[0].valid && cr_reg[1].valid
                         && cr_reg[2].valid && cr_reg[3].valid;
            exx_reg <= DIFF_W'(cr_reg[1].pos_x) - DIFF_W'(cr_reg[0].pos_x);
            exy_reg <= DIFF_W'(cr_reg[1].pos_y) - DIFF_W'(cr_reg[0].pos_y);
            eyx_reg <= DIFF_W'(cr_reg[2].pos_x) - DIFF_W'(cr_reg[0].pos_x);
            eyy_reg <= DIFF_W'(cr_reg[2].pos_y) - DIFF_W'(cr_reg[0].pos_y);
            ox_reg  <= DIFF_W'(s2_px_reg) - DIFF_W'(cr_reg[0].pos_x);
            oy_reg  <= DIFF_W'(s2_py_reg) - DIFF_W'(cr_reg[0].pos_y);
            s3_side_reg.fb   <= 1'b1;
            s3_side_reg.fb_x <= s2_fbx_reg;
            s3_side_reg.fb_y <= s2_fby_reg;
            for (int k = 0; k < 4; k++)
            begin
                s3_side_reg.cn_x[k] <= cr_reg[k].nrm_x;
                s3_side_reg.cn_y[k] <= cr_reg[k].nrm_y;
            end
        end
    end

    // ---------------- stage 4: cross products
    logic                     s4_v_reg;
    logic                     s4_ok_reg;
    logic signed [PROD_W-1:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg, p_e_reg, p_f_reg;
    blend_side_t              s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg     <= exx_reg * eyy_reg;
            p_b_reg     <= eyx_reg * exy_reg;
            p_c_reg     <= ox_reg * eyy_reg;
            p_d_reg     <= eyx_reg * oy_reg;
            p_e_reg     <= exx_reg * oy_reg;
            p_f_reg     <= ox_reg * exy_reg;
            s4_ok_reg   <= s3_ok_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // ---------------- stage 5: determinant and numerators
    logic                    s5_v_reg;
    logic                    s5_ok_reg;
    logic signed [DET_W-1:0] det_reg, numx_reg, numy_reg;
    blend_side_t             s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg     <= DET_W'(p_a_reg) - DET_W'(p_b_reg);
            numx_reg    <= DET_W'(p_c_reg) - DET_W'(p_d_reg);
            numy_reg    <= DET_W'(p_e_reg) - DET_W'(p_f_reg);
            s5_ok_reg   <= s4_ok_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    div_in_t din;

    always_comb
    begin
        din.d       = det_reg[DET_W-1]  ? DET_W'(-det_reg)  : det_reg;
        din.n_x     = numx_reg[DET_W-1] ? DET_W'(-numx_reg) : numx_reg;
        din.n_y     = numy_reg[DET_W-1] ? DET_W'(-numy_reg) : numy_reg;
        din.zero_x  = numx_reg == '0 || numx_reg[DET_W-1] != det_reg[DET_W-1];
        din.zero_y  = numy_reg == '0 || numy_reg[DET_W-1] != det_reg[DET_W-1];
        din.side    = s5_side_reg;
        din.side.fb = !s5_ok_reg || det_reg == '0;
    end

    logic                 dv;
    logic [FRAC_BITS:0]   fx;
    logic [FRAC_BITS:0]   fy;
    blend_side_t          dside;

    qbn_frac_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (s5_v_reg),
        .din    (din),
        .out_v  (dv),
        .frac_x (fx),
        .frac_y (fy),
        .side   (dside)
    );

    // ---------------- blend stages
    logic                  b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    logic [FRAC_BITS:0]    ay1_reg, by1_reg, ay2_reg, by2_reg;
    logic signed [MW-1:0]  px_reg [4];
    logic signed [MW-1:0]  py_reg [4];
    logic signed [TOP_W-1:0] topx_reg, botx_reg, topy_reg, boty_reg;
    logic signed [HP_W-1:0]  hx_a_reg, hx_b_reg, hy_a_reg, hy_b_reg;
    logic [LP_W-1:0]         lx_a_reg, lx_b_reg, ly_a_reg, ly_b_reg;
    logic signed [HP_W:0]    hx_reg, hy_reg;
    logic [LP_W:0]           lx_reg, ly_reg;
    logic        fb1_reg, fb2_reg, fb3_reg, fb4_reg;
    logic signed [NRM_W-1:0] fbx1_reg, fbx2_reg, fbx3_reg, fbx4_reg;
    logic signed [NRM_W-1:0] fby1_reg, fby2_reg, fby3_reg, fby4_reg;
    logic [FRAC_BITS:0]      ax;
    logic [FRAC_BITS:0]      ay;

    assign ax = FRAC_ONE - fx;
    assign ay = FRAC_ONE - fy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                // corners 0 and 2 take the left weight, 1 and 3 the right one
                px_reg[k] <= $signed({1'b0, (k % 2 == 0) ? ax : fx})
                             * $signed(dside.cn_x[k]);
                py_reg[k] <= $signed({1'b0, (k % 2 == 0) ? ax : fx})
                             * $signed(dside.cn_y[k]);
            end
            ay1_reg  <= ay;
            by1_reg  <= fy;
            fb1_reg  <= dside.fb;
            fbx1_reg <= dside.fb_x;
            fby1_reg <= dside.fb_y;

            topx_reg <= TOP_W'(px_reg[0]) + TOP_W'(px_reg[1]);
            botx_reg <= TOP_W'(px_reg[2]) + TOP_W'(px_reg[3]);
            topy_reg <= TOP_W'(py_reg[0]) + TOP_W'(py_reg[1]);
            boty_reg <= TOP_W'(py_reg[2]) + TOP_W'(py_reg[3]);
            ay2_reg  <= ay1_reg;
            by2_reg  <= by1_reg;
            fb2_reg  <= fb1_reg;
            fbx2_reg <= fbx1_reg;
            fby2_reg <= fby1_reg;

            // row blend split into high and low halves of the row sums
            hx_a_reg <= $signed({1'b0, ay2_reg}) * $signed(topx_reg[TOP_W-1:LO_W]);
            hx_b_reg <= $signed({1'b0, by2_reg}) * $signed(botx_reg[TOP_W-1:LO_W]);
            hy_a_reg <= $signed({1'b0, ay2_reg}) * $signed(topy_reg[TOP_W-1:LO_W]);
            hy_b_reg <= $signed({1'b0, by2_reg}) * $signed(boty_reg[TOP_W-1:LO_W]);
            lx_a_reg <= LP_W'(ay2_reg) * LP_W'(topx_reg[LO_W-1:0]);
            lx_b_reg <= LP_W'(by2_reg) * LP_W'(botx_reg[LO_W-1:0]);
            ly_a_reg <= LP_W'(ay2_reg) * LP_W'(topy_reg[LO_W-1:0]);
            ly_b_reg <= LP_W'(by2_reg) * LP_W'(boty_reg[LO_W-1:0]);
            fb3_reg  <= fb2_reg;
            fbx3_reg <= fbx2_reg;
            fby3_reg <= fby2_reg;

            hx_reg   <= (HP_W + 1)'(hx_a_reg) + (HP_W + 1)'(hx_b_reg);
            hy_reg   <= (HP_W + 1)'(hy_a_reg) + (HP_W + 1)'(hy_b_reg);
            lx_reg   <= (LP_W + 1)'(lx_a_reg) + (LP_W + 1)'(lx_b_reg);
            ly_reg   <= (LP_W + 1)'(ly_a_reg) + (LP_W + 1)'(ly_b_reg);
            fb4_reg  <= fb3_reg;
            fbx4_reg <= fbx3_reg;
            fby4_reg <= fby3_reg;
        end
    end

    logic [VW-1:0] vx;
    logic [VW-1:0] vy;

    // Q.40 sum, rounded half up to Q.20
    assign vx = (VW'(hx_reg) << LO_W) + VW'(lx_reg) + (VW'(1) << (RSH - 1));
    assign vy = (VW'(hy_reg) << LO_W) + VW'(ly_reg) + (VW'(1) << (RSH - 1));

    assign oq_push     = en && b4_v_reg;
    assign oq_in.status = fb4_reg;
    assign oq_in.x     = fb4_reg ? fbx4_reg : vx[RSH+NRM_W-1:RSH];
    assign oq_in.y     = fb4_reg ? fby4_reg : vy[RSH+NRM_W-1:RSH];

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= mid_pop;
            s2_v_reg <= s1_v_reg && s1_reg.it.action == ACT_QUERY;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            b1_v_reg <= dv;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
        end
    end

    // ---------------- result queue
    logic oq_pop;
    assign oq_pop = res_pop && !res_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 2'd1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_cnt_reg <= oq_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= oq_in;
        end
    end

endmodule

### rtl/core/quad_bilinear_normal_interp.sv
// Quad bilinear normal interpolator. Load seeds with action 0 (entry_index,
// position, normal, valid); query with action 1 (nearest seed index and the
// query pixel) and one result comes back per query, in order, while loads
// return nothing. Sustained rate is one item per clock in either mix while
// full stays low; an item goes through the width divider in the front, into
// the middle queue, through two seed-store reads, the edge and determinant
// math, the two pipelined fraction dividers and the blend and result queue
// write. After reset the seed valid bits are cleared by a pass over the whole
// store; full stays high during that pass, configuration writes are taken at
// all times. Write grid_width/grid_height only while idle.
module quad_bilinear_normal_interp (
    input  logic                              clk,
    input  logic                              rst_n,
    // input queue side
    input  logic                              push,
    output logic                              full,
    input  logic                              action,
    input  logic [qbn_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [qbn_pkg::PIX_W-1:0]  pixel_x,
    input  logic signed [qbn_pkg::PIX_W-1:0]  pixel_y,
    input  logic signed [qbn_pkg::NRM_W-1:0]  normal_x,
    input  logic signed [qbn_pkg::NRM_W-1:0]  normal_y,
    input  logic                              entry_valid,
    // result queue side
    output logic                              empty,
    input  logic                              pop,
    output logic                              status,
    output logic signed [qbn_pkg::NRM_W-1:0]  out_x,
    output logic signed [qbn_pkg::NRM_W-1:0]  out_y,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qbn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qbn_pkg::DIM_W-1:0]         cfg_data
);
    import qbn_pkg::*;

    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    grid_cfg_t        cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions are used clamped to 2..64
    always_comb
    begin
        cfg.w = grid_width_reg < DIM_MIN ? DIM_MIN :
                grid_width_reg > DIM_MAX ? DIM_MAX : grid_width_reg;
        cfg.h = grid_height_reg < DIM_MIN ? DIM_MIN :
                grid_height_reg > DIM_MAX ? DIM_MAX : grid_height_reg;
    end

    item_t       in_item;
    logic        front_stall;
    logic        clearing;
    logic        accept;
    logic        mid_push;
    mid_item_t   mid_in;
    mid_item_t   mid_head;
    mid_status_t mid_st;
    logic        mid_pop;
    result_t     res;

    assign in_item.action      = action;
    assign in_item.entry_index = entry_index;
    assign in_item.pixel_x     = pixel_x;
    assign in_item.pixel_y     = pixel_y;
    assign in_item.normal_x    = normal_x;
    assign in_item.normal_y    = normal_y;
    assign in_item.entry_valid = entry_valid;

    assign full   = front_stall || clearing;
    assign accept = push && !full;

    // front: accepts, splits the index into grid column and row
    qbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (accept),
        .in_item  (in_item),
        .mid_st   (mid_st),
        .stall    (front_stall),
        .mid_push (mid_push),
        .mid_item (mid_in)
    );

    // short queue between front and back
    qbn_mid_fifo u_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (mid_push),
        .in_item  (mid_in),
        .pop      (mid_pop),
        .out_item (mid_head),
        .st       (mid_st)
    );

    // back: seed stores, quad math, blend and result queue
    qbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_st    (mid_st),
        .head      (mid_head),
        .mid_pop   (mid_pop),
        .clearing  (clearing),
        .res_pop   (pop),
        .res_empty (empty),
        .res       (res)
    );

    assign status = res.status;
    assign out_x  = res.x;
    assign out_y  = res.y;

    // no item is taken while the valid bits are being cleared
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("input taken during clearing pass");

    // nothing can be waiting in the result queue during the clearing pass
    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> empty)
        else $error("result present during clearing pass");

    // front never transfers into a full middle queue
    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_st.full)
        else $error("middle queue overflow");

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qbn_pkg::*;

    // Scoreboard: keeps its own copy of the seed grid and the grid shape,
    // predicts the result of every accepted query, and checks popped results
    // against the oldest prediction.
    class normal_scoreboard;
        int              errors;
        result_t         pending[$];
        int              seed_px [MAX_SEEDS];
        int              seed_py [MAX_SEEDS];
        int              seed_nx [MAX_SEEDS];
        int              seed_ny [MAX_SEEDS];
        bit              seed_ok [MAX_SEEDS];
        bit [DIM_W-1:0]  reg_w;
        bit [DIM_W-1:0]  reg_h;

        function new();
            errors = 0;
            reg_w = DIM_RESET;
            reg_h = DIM_RESET;
            foreach (seed_ok[i])
            begin
                seed_px[i] = 0; seed_py[i] = 0;
                seed_nx[i] = 0; seed_ny[i] = 0;
                seed_ok[i] = 0;
            end
        endfunction

        function int eff_dim(bit [DIM_W-1:0] v);
            if (v < DIM_MIN) return DIM_MIN;
            if (v > DIM_MAX) return DIM_MAX;
            return v;
        endfunction

        // clamp(num/den, 0, 1) as Q0.20, truncated
        function longint unsigned frac_of(longint num, longint den);
            longint unsigned n, d, r, q;
            if (num == 0 || ((num < 0) != (den < 0))) return 0;
            n = num < 0 ? -num : num;
            d = den < 0 ? -den : den;
            if (n >= d) return 64'd1 << FRAC_BITS;
            r = n;
            q = 0;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        // bilinear mix at Q.40, rounded to Q4.20 with halves upward
        function logic [NRM_W-1:0] mix(longint fx, longint fy, longint n00,
                                       longint n10, longint n01, longint n11);
            longint one, top, bot, acc;
            one = longint'(1) << FRAC_BITS;
            top = (one - fx) * n00 + fx * n10;
            bot = (one - fx) * n01 + fx * n11;
            acc = (one - fy) * top + fy * bot;
            acc = acc + (longint'(1) <<< 39);
            acc = acc >>> 40;
            return acc[NRM_W-1:0];
        endfunction

        function void note_item(item_t it);
            int      idx, w, h, qx, qy;
            int      c[4];
            bit      usable;
            longint  exx, exy, eyx, eyy, ox, oy, det, fx, fy;
            result_t r;
            idx = it.entry_index;
            if (it.action == ACT_LOAD)
            begin
                seed_px[idx] = it.pixel_x;
                seed_py[idx] = it.pixel_y;
                seed_nx[idx] = it.normal_x;
                seed_ny[idx] = it.normal_y;
                seed_ok[idx] = it.entry_valid;
                return;
            end
            w = eff_dim(reg_w);
            h = eff_dim(reg_h);
            if (idx >= w * h)
            begin
                r.status = 1'b1; r.x = '0; r.y = '0;
                pending.push_back(r);
                return;
            end
            qx = idx % w;
            qy = idx / w;
            if (it.pixel_x < seed_px[idx]) qx--;
            if (it.pixel_y < seed_py[idx]) qy--;
            if (qx < 0) qx = 0;
            if (qx > w - 2) qx = w - 2;
            if (qy < 0) qy = 0;
            if (qy > h - 2) qy = h - 2;
            c[0] = qy * w + qx;
            c[1] = c[0] + 1;
            c[2] = c[0] + w;
            c[3] = c[2] + 1;
            usable = 1;
            foreach (c[k])
                if (c[k] >= MAX_SEEDS || !seed_ok[c[k]]) usable = 0;
            if (usable)
            begin
                exx = longint'(seed_px[c[1]]) - seed_px[c[0]];
                exy = longint'(seed_py[c[1]]) - seed_py[c[0]];
                eyx = longint'(seed_px[c[2]]) - seed_px[c[0]];
                eyy = longint'(seed_py[c[2]]) - seed_py[c[0]];
                ox  = longint'(it.pixel_x) - seed_px[c[0]];
                oy  = longint'(it.pixel_y) - seed_py[c[0]];
                det = exx * eyy - eyx * exy;
                if (det != 0)
                begin
                    fx = frac_of(ox * eyy - eyx * oy, det);
                    fy = frac_of(exx * oy - ox * exy, det);
                    r.status = 1'b0;
                    r.x = mix(fx, fy, seed_nx[c[0]], seed_nx[c[1]],
                              seed_nx[c[2]], seed_nx[c[3]]);
                    r.y = mix(fx, fy, seed_ny[c[0]], seed_ny[c[1]],
                              seed_ny[c[2]], seed_ny[c[3]]);
                    pending.push_back(r);
                    return;
                end
            end
            // unusable quad: nearest seed's own normal
            r.status = 1'b1;
            r.x = NRM_W'(seed_nx[idx]);
            r.y = NRM_W'(seed_ny[idx]);
            pending.push_back(r);
        endfunction

        function void check_result(logic st, logic [NRM_W-1:0] x, logic [NRM_W-1:0] y);
            result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: status %0d x %h y %h", st, x, y);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (x !== e.x)
            begin
                $error("out_x: expected %h, got %h", e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $error("out_y: expected %h, got %h", e.y, y);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 100;   // past the end of the pipeline

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic signed [PIX_W-1:0]  pixel_x;
    logic signed [PIX_W-1:0]  pixel_y;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic                     entry_valid;
    logic                     empty;
    logic                     pop;
    logic                     status;
    logic signed [NRM_W-1:0]  out_x;
    logic signed [NRM_W-1:0]  out_y;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DIM_W-1:0]         cfg_data;

    normal_scoreboard sb;
    int  accepted_items;
    int  cycle_count;

    quad_bilinear_normal_interp DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog; the valid clear after reset is well inside this
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("quad_bilinear_normal_interp verification failed");
            $finish;
        end
    end

    // result side: a pop is a transfer when empty is low at the edge
    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_result(status, out_x, out_y);

    // receiver stall pattern; one long hold-off once ~150 items went in so
    // the internal queues fill and full backs up onto the sender
    initial
    begin
        int  mode;
        bit  held;
        held = 0;
        mode = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cycle_count % 64 == 0) mode = $urandom_range(0, 2);
            if (!held && accepted_items >= 150)
            begin
                held = 1;
                pop <= 1'b0;
                repeat (800) @(negedge clk);
            end
            case (mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(item_t it);
        @(negedge clk);
        push        <= 1'b1;
        action      <= it.action;
        entry_index <= it.entry_index;
        pixel_x     <= it.pixel_x;
        pixel_y     <= it.pixel_y;
        normal_x    <= it.normal_x;
        normal_y    <= it.normal_y;
        entry_valid <= it.entry_valid;
        do @(posedge clk); while (full);
        sb.note_item(it);
        accepted_items++;
    endtask

    // burst/gap shaping of the sender
    int burst_left;
    task automatic maybe_gap();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap == 0) return;
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (which == CFG_GRID_WIDTH) sb.reg_w = val;
        else sb.reg_h = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain: loads give no result, so wait out the pipeline after the last one
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic item_t make_load(int idx, int x, int y, bit ok);
        item_t it;
        it.action      = ACT_LOAD;
        it.entry_index = IDX_W'(idx);
        it.pixel_x     = PIX_W'(x);
        it.pixel_y     = PIX_W'(y);
        it.normal_x    = NRM_W'($urandom);
        it.normal_y    = NRM_W'($urandom);
        it.entry_valid = ok;
        return it;
    endfunction

    function automatic item_t make_query(int idx, int x, int y);
        item_t it;
        it.action      = ACT_QUERY;
        it.entry_index = IDX_W'(idx);
        it.pixel_x     = PIX_W'(x);
        it.pixel_y     = PIX_W'(y);
        it.normal_x    = NRM_W'($urandom);   // ignored on a query
        it.normal_y    = NRM_W'($urandom);
        it.entry_valid = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // one grid setting: load a (possibly degenerate) grid, then query it
    task automatic run_phase(logic [DIM_W-1:0] wv, logic [DIM_W-1:0] hv, int nq);
        int    w, h, nload, step, idx, span;
        item_t it;
        write_reg(CFG_GRID_WIDTH, wv);
        write_reg(CFG_GRID_HEIGHT, hv);
        w = sb.eff_dim(wv);
        h = sb.eff_dim(hv);
        nload = (w * h < 100) ? w * h : 100;
        // step 0 collapses the grid so the determinant is zero
        step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(16, 60000);
        for (int i = 0; i < nload; i++)
        begin
            it = make_load(i, (i % w) * step + $signed($urandom_range(0, 64)) - 32,
                           (i / w) * step + $signed($urandom_range(0, 64)) - 32,
                           $urandom_range(0, 15) != 0);
            send_item(it);
            maybe_gap();
        end
        span = 2 * step + 64;
        for (int q = 0; q < nq; q++)
        begin
            case ($urandom_range(0, 19))
                0: begin
                    // stray load anywhere in the store
                    send_item(make_load($urandom_range(0, MAX_SEEDS - 1), $urandom,
                                        $urandom, 1'($urandom_range(0, 1))));
                end
                1: begin
                    if (w * h < MAX_SEEDS)
                        idx = $urandom_range(w * h, MAX_SEEDS - 1);
                    else
                        idx = $urandom_range(0, nload - 1);
                    send_item(make_query(idx, $urandom, $urandom));
                end
                2: begin
                    idx = $urandom_range(0, nload - 1);
                    send_item(make_query(idx, $urandom, $urandom));
                end
                default: begin
                    idx = $urandom_range(0, nload - 1);
                    send_item(make_query(idx,
                        sb.seed_px[idx] + $signed($urandom_range(0, 2 * span)) - span,
                        sb.seed_py[idx] + $signed($urandom_range(0, 2 * span)) - span));
                end
            endcase
            maybe_gap();
        end
        settle();
    endtask

    initial
    begin
        item_t it;
        accepted_items = 0;
        cycle_count    = 0;
        burst_left     = 0;
        sb = new();
        rst_n       = 1'b0;
        push        = 1'b0;
        action      = ACT_LOAD;
        entry_index = '0;
        pixel_x     = '0;
        pixel_y     = '0;
        normal_x    = '0;
        normal_y    = '0;
        entry_valid = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_GRID_WIDTH;
        cfg_data    = DIM_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 2x2 square with extreme normals, then edge-case queries
        it = make_load(0, 0, 0, 1);
        it.normal_x = 24'sh7FFFFF; it.normal_y = -24'sh800000;
        send_item(it);
        it = make_load(1, 1024, 0, 1);
        it.normal_x = -24'sh800000; it.normal_y = 24'sh7FFFFF;
        send_item(it);
        it = make_load(2, 0, 1024, 1);
        it.normal_x = 24'sh7FFFFF; it.normal_y = 24'sh7FFFFF;
        send_item(it);
        it = make_load(3, 1024, 1024, 1);
        it.normal_x = -24'sh800000; it.normal_y = -24'sh800000;
        send_item(it);
        send_item(make_query(0, 512, 512));                       // center
        send_item(make_query(3, 24'sh7FFFFF, 24'sh7FFFFF));       // clamps to 1
        send_item(make_query(0, -24'sh800000, -24'sh800000));     // clamps to 0
        send_item(make_query(1, 0, 1024));
        send_item(make_query(MAX_SEEDS - 1, 0, 0));               // outside grid
        send_item(make_load(MAX_SEEDS - 1, 24'sh7FFFFF, -24'sh800000, 1));
        send_item(make_load(2, 0, 1024, 0));                      // invalid corner
        send_item(make_query(0, 100, 100));
        send_item(make_load(2, 1024, 0, 1));                      // det zero
        send_item(make_query(0, 100, 100));
        settle();

        // random phases through several grid shapes, extremes included
        run_phase(7'd2, 7'd2, 65);
        run_phase(7'd64, 7'd64, 70);
        run_phase(7'd0, 7'd127, 65);
        run_phase(7'd5, 7'd3, 70);
        run_phase(7'd127, 7'd1, 65);
        run_phase(7'd9, 7'd11, 70);
        run_phase(7'd3, 7'd64, 65);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("quad_bilinear_normal_interp verification clean");
        else
            $display("quad_bilinear_normal_interp verification failed");
        $finish;
    end
endmodule
